[hw/rtl/etu_pkg.sv]
// Package: constants, types and helpers for the epoch to UTC calendar block.
package etu_pkg;

    localparam logic [31:0] MS_PER_SEC    = 32'd1000;
    localparam logic [31:0] SECS_PER_DAY  = 32'd86400;
    localparam logic [31:0] SECS_PER_HOUR = 32'd3600;
    localparam logic [31:0] SECS_PER_MIN  = 32'd60;
    // floor(x / d) = (x * RECIP) >> SH, exact over the operand range noted
    localparam logic [31:0] RECIP_MS      = 32'd274877907;  // d 1000, x < 2^32
    localparam logic [31:0] RECIP_DAY     = 32'd50903317;   // d 675, x < 2^25
    localparam logic [31:0] RECIP_HOUR    = 32'd9321;       // d 225, x < 2^13
    localparam logic [31:0] RECIP_MIN     = 32'd1093;       // d 15, x < 2^10
    localparam int          SH_MS         = 38;
    localparam int          SH_DAY        = 35;
    localparam int          SH_HOUR       = 21;
    localparam int          SH_MIN        = 14;
    localparam logic [15:0] DAYS_TO_2000  = 16'd10957;
    localparam logic [15:0] DAYS_LEAP     = 16'd366;
    localparam logic [15:0] DAYS_COMMON   = 16'd365;
    localparam logic [15:0] DAYS_QUAD     = 16'd1461;
    localparam logic [11:0] YEAR_1970     = 12'd1970;
    localparam logic [11:0] YEAR_2000     = 12'd2000;
    localparam logic [11:0] YEAR_2100     = 12'd2100;

    typedef enum logic {
        CFG_EPOCH_BASE = 1'b0,
        CFG_MILLIS_MARK = 1'b1
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MSQ,
        S_MSR,
        S_DAY,
        S_TOD,
        S_HOUR,
        S_HREM,
        S_MIN,
        S_SEC,
        S_YINIT,
        S_YEAR,
        S_MONTH,
        S_DONE
    } t_state;

    // Years 1970..2106 only: 2100 is the one century year in range that is not leap.
    function automatic logic is_leap(input logic [11:0] y);
        return (y[1:0] == 2'b00) && (y != YEAR_2100);
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] d;
        unique case (m)
            4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: d = 5'd31;
            4'd3, 4'd5, 4'd8, 4'd10:                   d = 5'd30;
            4'd1:                                      d = leap ? 5'd29 : 5'd28;
            default:                                   d = 5'd31;
        endcase
        return d;
    endfunction

endpackage

[hw/rtl/epoch_to_utc_calendar_top.sv]
// Top level: millisecond count to UTC calendar fields or relative seconds.
// Unsynced path: quotient, remainder and done states after accept.
// Synced path: the multiply states S_MSQ through S_SEC, the year setup state,
// the year loop, the month loop and the done state.
// One shared 32x32 multiplier does every divide by reciprocal; o_busy stays high
// through the o_valid cycle, so one word at a time. Sync active-low reset clears
// the sequencer and both config registers.
module epoch_to_utc_calendar_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [31:0] i_millis_now,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  etu_pkg::t_cfg_idx i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output logic        o_valid,
    output logic        o_synced,
    output logic [11:0] o_year,
    output logic [3:0]  o_month,
    output logic [4:0]  o_day,
    output logic [4:0]  o_hour,
    output logic [5:0]  o_minute,
    output logic [5:0]  o_second,
    output logic [22:0] o_rel_seconds,
    output logic [9:0]  o_rel_millis
);
    import etu_pkg::*;

    t_state      r_state, n_state;
    logic [31:0] r_base, r_mark;
    logic [31:0] r_x, n_x;
    logic [31:0] r_ma, n_ma;
    logic [31:0] r_mb, n_mb;
    logic [22:0] r_q, n_q;
    logic [9:0]  r_rem, n_rem;
    logic        r_synced, n_synced;
    logic [15:0] r_days, n_days;
    logic [11:0] r_year, n_year;
    logic [3:0]  r_mon, n_mon;
    logic [4:0]  r_hour, n_hour;
    logic [5:0]  r_min, n_min;
    logic [5:0]  r_sec, n_sec;

    logic [63:0] w_prod;
    logic [31:0] w_diff;
    logic [22:0] w_q_ms;
    logic [31:0] w_now;
    logic [15:0] w_q_day;
    logic [4:0]  w_q_hour;
    logic [5:0]  w_q_min;
    logic [31:0] w_first;
    logic        w_leap;
    logic [15:0] w_ylen, w_qlen, w_dim;
    logic        w_quad, w_ystep, w_mstep;

    // shared multiplier, quotient taps and remainder
    always_comb begin
        w_prod   = {32'd0, r_ma} * {32'd0, r_mb};
        w_diff   = r_x - w_prod[31:0];
        w_q_ms   = w_prod[SH_MS +: 23];
        w_now    = r_base + {9'd0, w_q_ms};
        w_q_day  = w_prod[SH_DAY +: 16];
        w_q_hour = w_prod[SH_HOUR +: 5];
        w_q_min  = w_prod[SH_MIN +: 6];
        w_first  = (r_base != 32'd0) ? i_millis_now - r_mark : i_millis_now;
    end

    // year and month step conditions
    always_comb begin
        w_leap  = is_leap(r_year);
        w_ylen  = w_leap ? DAYS_LEAP : DAYS_COMMON;
        w_qlen  = (r_year == YEAR_2100) ? DAYS_QUAD - 16'd1 : DAYS_QUAD;
        w_quad  = (r_year[1:0] == 2'b00) && (r_days >= w_qlen);
        w_ystep = r_days >= w_ylen;
        w_dim   = {11'd0, month_len(r_mon, w_leap)};
        w_mstep = (r_days >= w_dim) && (r_mon < 4'd11);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_start) n_state = S_MSQ;
            S_MSQ:   n_state = r_synced ? S_DAY : S_MSR;
            S_MSR:   n_state = S_DONE;
            S_DAY:   n_state = S_TOD;
            S_TOD:   n_state = S_HOUR;
            S_HOUR:  n_state = S_HREM;
            S_HREM:  n_state = S_MIN;
            S_MIN:   n_state = S_SEC;
            S_SEC:   n_state = S_YINIT;
            S_YINIT: n_state = S_YEAR;
            S_YEAR:  if (!w_quad && !w_ystep) n_state = S_MONTH;
            S_MONTH: if (!w_mstep) n_state = S_DONE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_x      = r_x;
        n_ma     = r_ma;
        n_mb     = r_mb;
        n_q      = r_q;
        n_rem    = r_rem;
        n_synced = r_synced;
        n_days   = r_days;
        n_year   = r_year;
        n_mon    = r_mon;
        n_hour   = r_hour;
        n_min    = r_min;
        n_sec    = r_sec;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_synced = (r_base != 32'd0);
                    n_x      = w_first;
                    n_ma     = w_first;
                    n_mb     = RECIP_MS;
                end
            end
            S_MSQ: begin
                n_q = w_q_ms;
                if (r_synced) begin
                    // divide by 86400 as by 128 then by 675
                    n_x  = w_now;
                    n_ma = {7'd0, w_now[31:7]};
                    n_mb = RECIP_DAY;
                end else begin
                    n_ma = {9'd0, w_q_ms};
                    n_mb = MS_PER_SEC;
                end
            end
            S_MSR: n_rem = w_diff[9:0];
            S_DAY: begin
                n_days = w_q_day;
                n_ma   = {16'd0, w_q_day};
                n_mb   = SECS_PER_DAY;
            end
            S_TOD: begin
                n_x  = w_diff;
                n_ma = {19'd0, w_diff[16:4]};
                n_mb = RECIP_HOUR;
            end
            S_HOUR: begin
                n_hour = w_q_hour;
                n_ma   = {27'd0, w_q_hour};
                n_mb   = SECS_PER_HOUR;
            end
            S_HREM: begin
                n_x  = w_diff;
                n_ma = {22'd0, w_diff[11:2]};
                n_mb = RECIP_MIN;
            end
            S_MIN: begin
                n_min = w_q_min;
                n_ma  = {26'd0, w_q_min};
                n_mb  = SECS_PER_MIN;
            end
            S_SEC: n_sec = w_diff[5:0];
            S_YINIT: begin
                n_mon = 4'd0;
                if (r_days >= DAYS_TO_2000) begin
                    n_year = YEAR_2000;
                    n_days = r_days - DAYS_TO_2000;
                end else begin
                    n_year = YEAR_1970;
                end
            end
            S_YEAR: begin
                if (w_quad) begin
                    n_days = r_days - w_qlen;
                    n_year = r_year + 12'd4;
                end else if (w_ystep) begin
                    n_days = r_days - w_ylen;
                    n_year = r_year + 12'd1;
                end
            end
            S_MONTH: begin
                if (w_mstep) begin
                    n_days = r_days - w_dim;
                    n_mon  = r_mon + 4'd1;
                end
            end
            S_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_base  <= '0;
            r_mark  <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_EPOCH_BASE:  r_base <= i_cfg_data;
                    CFG_MILLIS_MARK: r_mark <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x      <= n_x;
        r_ma     <= n_ma;
        r_mb     <= n_mb;
        r_q      <= n_q;
        r_rem    <= n_rem;
        r_synced <= n_synced;
        r_days   <= n_days;
        r_year   <= n_year;
        r_mon    <= n_mon;
        r_hour   <= n_hour;
        r_min    <= n_min;
        r_sec    <= n_sec;
    end

    assign o_busy        = (r_state != S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign o_valid       = (r_state == S_DONE);
    assign o_synced      = r_synced;
    assign o_year        = r_synced ? r_year : '0;
    assign o_month       = r_synced ? r_mon + 4'd1 : '0;
    assign o_day         = r_synced ? r_days[4:0] + 5'd1 : '0;
    assign o_hour        = r_synced ? r_hour : '0;
    assign o_minute      = r_synced ? r_min : '0;
    assign o_second      = r_synced ? r_sec : '0;
    assign o_rel_seconds = r_synced ? '0 : r_q;
    assign o_rel_millis  = r_synced ? '0 : r_rem;

endmodule

[hw/rtl/etu_checker.sv]
// Port-level checker for the epoch to UTC calendar block, with its bind.
module etu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_start,
    input logic        o_busy,
    input logic        o_valid,
    input logic        o_synced,
    input logic [11:0] o_year,
    input logic [3:0]  o_month,
    input logic [4:0]  o_day,
    input logic [4:0]  o_hour,
    input logic [5:0]  o_minute,
    input logic [5:0]  o_second,
    input logic [9:0]  o_rel_millis
);
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_busy) else $error("result word outside busy window");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (o_busy && !o_valid))
        else $error("accepted word did not raise busy");

    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> (!o_valid && !o_busy)) else $error("result strobe longer than one cycle");

    a_cal_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_synced) |-> (o_month >= 4'd1 && o_month <= 4'd12 && o_day >= 5'd1
            && o_hour <= 5'd23 && o_minute <= 6'd59 && o_second <= 6'd59
            && o_year >= 12'd1970 && o_year <= 12'd2106))
        else $error("calendar field out of range");

    a_rel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_synced) |-> (o_rel_millis <= 10'd999 && o_year == 12'd0))
        else $error("relative word malformed");

endmodule

bind epoch_to_utc_calendar_top etu_checker u_etu_checker (.*);

[tb/utc_calendar_checker.sv]
// Checker: predicts UTC calendar words from accepted counts and compares results.
`timescale 1ns / 100ps

module utc_calendar_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  logic [31:0]       i_millis_now,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  etu_pkg::t_cfg_idx i_cfg_index,
    input  logic [31:0]       i_cfg_data,
    input  logic              i_valid,
    input  logic              i_synced,
    input  logic [11:0]       i_year,
    input  logic [3:0]        i_month,
    input  logic [4:0]        i_day,
    input  logic [4:0]        i_hour,
    input  logic [5:0]        i_minute,
    input  logic [5:0]        i_second,
    input  logic [22:0]       i_rel_seconds,
    input  logic [9:0]        i_rel_millis,
    output int                o_errors,
    output int                o_pending
);

    typedef struct packed {
        logic        synced;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [22:0] rel_seconds;
        logic [9:0]  rel_millis;
    } t_utc_word;

    logic [31:0] epoch_base;
    logic [31:0] millis_mark;
    t_utc_word   utc_expect_q[$];
    t_utc_word   want;
    t_utc_word   got;

    initial begin
        o_errors = 0;
        o_pending = 0;
        epoch_base = '0;
        millis_mark = '0;
    end

    function automatic logic [31:0] year_len(input logic [31:0] y);
        if ((y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0)))
            return 32'd366;
        return 32'd365;
    endfunction

    function automatic logic [31:0] mon_len(input int m, input bit leap);
        case (m)
            1:          return leap ? 32'd29 : 32'd28;
            3, 5, 8, 10: return 32'd30;
            default:    return 32'd31;
        endcase
    endfunction

    function automatic t_utc_word utc_from_millis(input logic [31:0] ms,
                                                  input logic [31:0] base,
                                                  input logic [31:0] mark);
        t_utc_word   r;
        logic [31:0] elapsed;
        logic [31:0] now;
        logic [31:0] tod;
        logic [31:0] days;
        logic [31:0] yr;
        bit          leap;
        int          m;
        r = '0;
        if (base == 32'd0) begin
            r.rel_seconds = 23'(ms / 32'd1000);
            r.rel_millis  = 10'(ms % 32'd1000);
        end else begin
            elapsed = ms - mark;
            now = base + elapsed / 32'd1000;
            tod = now % 32'd86400;
            days = now / 32'd86400;
            if (days >= 32'd10957) begin
                yr = 32'd2000;
                days = days - 32'd10957;
            end else begin
                yr = 32'd1970;
            end
            while (days >= year_len(yr)) begin
                days = days - year_len(yr);
                yr = yr + 1;
            end
            leap = (year_len(yr) == 32'd366);
            m = 0;
            while (m < 12 && days >= mon_len(m, leap)) begin
                days = days - mon_len(m, leap);
                m++;
            end
            r.synced = 1'b1;
            r.year   = 12'(yr);
            r.month  = 4'(m + 1);
            r.day    = 5'(days + 1);
            r.hour   = 5'(tod / 32'd3600);
            r.minute = 6'((tod % 32'd3600) / 32'd60);
            r.second = 6'(tod % 32'd60);
        end
        return r;
    endfunction

    task automatic report(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        o_errors++;
    endtask

    task automatic chk(input string name, input logic [31:0] g, input logic [31:0] w);
        if (g !== w)
            report($sformatf("%s got %0d want %0d", name, g, w));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            epoch_base = '0;
            millis_mark = '0;
            utc_expect_q.delete();
        end else begin
            if (i_valid === 1'b1) begin
                got = {i_synced, i_year, i_month, i_day, i_hour, i_minute, i_second,
                       i_rel_seconds, i_rel_millis};
                if (utc_expect_q.size() == 0) begin
                    report("result word with nothing expected");
                end else begin
                    want = utc_expect_q.pop_front();
                    chk("synced", 32'(got.synced), 32'(want.synced));
                    chk("year", 32'(got.year), 32'(want.year));
                    chk("month", 32'(got.month), 32'(want.month));
                    chk("day", 32'(got.day), 32'(want.day));
                    chk("hour", 32'(got.hour), 32'(want.hour));
                    chk("minute", 32'(got.minute), 32'(want.minute));
                    chk("second", 32'(got.second), 32'(want.second));
                    chk("rel_seconds", 32'(got.rel_seconds), 32'(want.rel_seconds));
                    chk("rel_millis", 32'(got.rel_millis), 32'(want.rel_millis));
                end
            end
            if (i_start && !i_busy)
                utc_expect_q.push_back(utc_from_millis(i_millis_now, epoch_base, millis_mark));
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    etu_pkg::CFG_EPOCH_BASE:  epoch_base = i_cfg_data;
                    etu_pkg::CFG_MILLIS_MARK: millis_mark = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending = utc_expect_q.size();
    end

endmodule

[tb/tb_top.sv]
// Testbench top: drives counts and epoch settings into the calendar block, gives the verdict.
`timescale 1ns / 100ps

module tb_top;

    import etu_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    logic [31:0] i_millis_now;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    t_cfg_idx    i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        o_valid;
    logic        o_synced;
    logic [11:0] o_year;
    logic [3:0]  o_month;
    logic [4:0]  o_day;
    logic [4:0]  o_hour;
    logic [5:0]  o_minute;
    logic [5:0]  o_second;
    logic [22:0] o_rel_seconds;
    logic [9:0]  o_rel_millis;
    int          errors;
    int          pending;
    int          n_sent;

    epoch_to_utc_calendar_top uut (.*);

    utc_calendar_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_busy(o_busy),
        .i_millis_now(i_millis_now), .i_cfg_valid(i_cfg_valid),
        .i_cfg_ready(o_cfg_ready), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_valid(o_valid), .i_synced(o_synced), .i_year(o_year), .i_month(o_month),
        .i_day(o_day), .i_hour(o_hour), .i_minute(o_minute), .i_second(o_second),
        .i_rel_seconds(o_rel_seconds), .i_rel_millis(o_rel_millis),
        .o_errors(errors), .o_pending(pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        #20_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 40) return 0;
        if (p < 90) return $urandom_range(1, 3);
        if (p < 98) return $urandom_range(4, 20);
        return $urandom_range(50, 200);
    endfunction

    // one count word, held until the block takes it
    task automatic put_millis(input logic [31:0] v);
        @(negedge i_clk);
        i_start = 1'b1;
        i_millis_now = v;
        do @(posedge i_clk); while (o_busy);
        n_sent++;
    endtask

    task automatic idle_gap();
        int n;
        n = gap_len();
        if (n > 0) begin
            @(negedge i_clk);
            i_start = 1'b0;
            i_millis_now = $urandom;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    task automatic wait_drain();
        @(negedge i_clk);
        i_start = 1'b0;
        while (pending != 0 || o_busy) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] d);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = d;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        i_cfg_data = $urandom;
    endtask

    task automatic set_epoch(input logic [31:0] base, input logic [31:0] mark);
        wait_drain();
        write_reg(CFG_EPOCH_BASE, base);
        write_reg(CFG_MILLIS_MARK, mark);
    endtask

    function automatic logic [31:0] pick_millis(input logic [31:0] mk);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return mk + $urandom_range(0, 86_400_000);
            6, 7:             return $urandom;
            8:                return mk + $urandom_range(0, 2999);
            default: begin
                case ($urandom_range(0, 3))
                    0:       return 32'h0;
                    1:       return 32'hFFFF_FFFF;
                    2:       return mk - 1;
                    default: return mk;
                endcase
            end
        endcase
    endfunction

    initial begin
        logic [31:0] base;
        logic [31:0] mark;
        int unsigned k;
        int          burst;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_millis_now = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_EPOCH_BASE;
        i_cfg_data = '0;
        n_sent = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // unsynced after reset
        put_millis(32'd0);
        put_millis(32'd999);
        put_millis(32'd1000);
        put_millis(32'hFFFF_FFFF);
        idle_gap();
        put_millis(32'h5555_5555);
        put_millis(32'hAAAA_AAAA);

        // smallest nonzero base
        set_epoch(32'd1, 32'd0);
        put_millis(32'd0);
        put_millis(32'hFFFF_FFFF);
        // leap day in a 400-year century
        set_epoch(32'd951782399, 32'd0);
        put_millis(32'd0);
        put_millis(32'd1000);
        put_millis(32'd86_401_000);
        // 2100 is not leap
        set_epoch(32'd4107542399, 32'd0);
        put_millis(32'd0);
        put_millis(32'd1000);
        // top of range and wrap of elapsed count and sum
        set_epoch(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        put_millis(32'hFFFF_FFFF);
        put_millis(32'd999);
        put_millis(32'hFFFF_FFFE);
        // end of a leap year
        set_epoch(32'd978307199, 32'd0);
        put_millis(32'd0);
        put_millis(32'd1000);
        // last day before the 2000 shortcut
        set_epoch(32'd946684799, 32'd123);
        put_millis(32'd123);
        put_millis(32'd1123);

        while (n_sent < 1650) begin
            case ($urandom_range(0, 9))
                0, 1: base = 32'd0;
                2:    base = 32'd1;
                3:    base = 32'hFFFF_FFFF;
                4, 5: begin
                    // two seconds before some midnight
                    k = $urandom_range(0, 49709);
                    base = 32'(k) * 32'd86400 + 32'd86398;
                end
                default: base = $urandom;
            endcase
            case ($urandom_range(0, 3))
                0:       mark = 32'd0;
                1:       mark = 32'hFFFF_FFFF;
                default: mark = $urandom;
            endcase
            set_epoch(base, mark);
            burst = $urandom_range(10, 60);
            repeat (burst) begin
                put_millis(pick_millis(mark));
                idle_gap();
            end
        end

        wait_drain();
        repeat (200) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/etu_pkg.sv
hw/rtl/epoch_to_utc_calendar_top.sv
hw/rtl/etu_checker.sv
tb/utc_calendar_checker.sv
tb/tb_top.sv
